>>> sv/hpq_pkg.sv
// ----------------------------------------------------------------------------
// hpq_pkg
// Shared types and codes for the binary max-heap priority queue.
// ----------------------------------------------------------------------------
package hpq_pkg;

	localparam int WORD_W   = 32;
	localparam int COUNT_W  = 11;
	localparam int STATUS_W = 2;

	typedef logic signed [WORD_W-1:0] word_t;
	typedef logic [COUNT_W-1:0]       count_t;
	typedef logic [STATUS_W-1:0]      status_t;
	typedef logic                     op_t;

	// Operation codes carried by the op field.
	localparam op_t OP_INSERT = 1'b0;
	localparam op_t OP_REMOVE = 1'b1;

	// Result status codes.
	localparam status_t ST_OK    = 2'd0;
	localparam status_t ST_EMPTY = 2'd1;
	localparam status_t ST_FULL  = 2'd2;

	// Value answered by a removal from an empty heap.
	localparam word_t WORD_NEG_ONE = -32'sd1;

	// Sequencer states, one-hot.
	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_POP  = 5'b00010,
		S_UP   = 5'b00100,
		S_DN   = 5'b01000,
		S_FIN  = 5'b10000
	} state_t;

endpackage

>>> sv/hpq_ram.sv
// ----------------------------------------------------------------------------
// hpq_ram
// Heap storage: one write port and two read ports, read data registered.
// ----------------------------------------------------------------------------
module hpq_ram #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10
) (
	input  logic               clk,
	input  logic               we,
	input  logic [AW-1:0]      waddr,
	input  hpq_pkg::word_t     wdata,
	input  logic               re,
	input  logic [AW-1:0]      raddr_a,
	input  logic [AW-1:0]      raddr_b,
	output hpq_pkg::word_t     rdata_a,
	output hpq_pkg::word_t     rdata_b
);
	import hpq_pkg::*;

	word_t mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Two registered read ports, used together for root/last and for both children.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_a <= mem[raddr_a];
			rdata_b <= mem[raddr_b];
		end
	end

endmodule

>>> sv/hpq_ctrl.sv
// ----------------------------------------------------------------------------
// hpq_ctrl
// Sequencer for insert and remove: hole-based sift up and sift down over
// the heap memory, element count and the registered result word.
// ----------------------------------------------------------------------------
module hpq_ctrl #(
	parameter int CAPACITY = 1024
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  hpq_pkg::op_t                         op,
	input  hpq_pkg::word_t                       value,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output hpq_pkg::word_t                       max_value,
	output hpq_pkg::status_t                     status,
	output hpq_pkg::count_t                      count,
	output logic                                 mem_we,
	output logic [$clog2(CAPACITY)-1:0]          mem_waddr,
	output hpq_pkg::word_t                       mem_wdata,
	output logic                                 mem_re,
	output logic [$clog2(CAPACITY)-1:0]          mem_raddr_a,
	output logic [$clog2(CAPACITY)-1:0]          mem_raddr_b,
	input  hpq_pkg::word_t                       mem_rdata_a,
	input  hpq_pkg::word_t                       mem_rdata_b
);
	import hpq_pkg::*;

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int PW = CW + 1;

	state_t          state_q, state_d;
	logic [CW-1:0]   cnt_q, cnt_d;
	logic [CW-1:0]   p_q, p_d;
	word_t           v_q, v_d;

	logic            out_valid_q;
	word_t           max_q;
	status_t         status_q;
	count_t          count_q;

	logic            load;
	word_t           ld_max;
	status_t         ld_status;
	logic [CW-1:0]   ld_count;

	logic            accept;
	logic [CW-1:0]   cnt_inc, cnt_dec, p_half;
	logic            up_gt;
	logic [PW-1:0]   child_l, child_r, best_pos, grand;
	logic            right_ok, take_l, take_r;
	word_t           pick, best_val;

	// Items are taken only between operations, and only when the result word can be loaded.
	assign in_stall = (state_q != S_IDLE) || (out_valid_q && out_stall);
	assign accept   = in_valid && !in_stall;

	assign cnt_inc = cnt_q + 1'b1;
	assign cnt_dec = cnt_q - 1'b1;
	assign p_half  = p_q >> 1;

	// Sift up compare: the new value against the parent just read.
	assign up_gt = v_q > mem_rdata_a;

	// Sift down choice: left child if larger than the moving value, then right if larger still.
	assign child_l  = {p_q, 1'b0};
	assign child_r  = {p_q, 1'b1};
	assign right_ok = child_r <= PW'(cnt_q);
	assign take_l   = mem_rdata_a > v_q;
	assign pick     = take_l ? mem_rdata_a : v_q;
	assign take_r   = right_ok && (mem_rdata_b > pick);
	assign best_pos = take_r ? child_r : child_l;
	assign best_val = take_r ? mem_rdata_b : mem_rdata_a;
	assign grand    = {best_pos[CW-1:0], 1'b0};

	// Next-state and memory access logic.
	always_comb begin
		state_d     = state_q;
		cnt_d       = cnt_q;
		p_d         = p_q;
		v_d         = v_q;
		load        = 1'b0;
		ld_max      = '0;
		ld_status   = ST_OK;
		ld_count    = cnt_q;
		mem_we      = 1'b0;
		mem_waddr   = AW'(p_q - 1'b1);
		mem_wdata   = v_q;
		mem_re      = 1'b0;
		mem_raddr_a = '0;
		mem_raddr_b = '0;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (op == OP_INSERT) begin
						if (cnt_q >= CW'(CAPACITY)) begin
							load      = 1'b1;
							ld_status = ST_FULL;
						end else begin
							load     = 1'b1;
							ld_count = cnt_inc;
							cnt_d    = cnt_inc;
							v_d      = value;
							p_d      = cnt_inc;
							if (cnt_q != '0) begin
								mem_re      = 1'b1;
								mem_raddr_a = AW'((cnt_inc >> 1) - 1'b1);
								state_d     = S_UP;
							end else begin
								state_d = S_FIN;
							end
						end
					end else begin
						if (cnt_q == '0) begin
							load      = 1'b1;
							ld_max    = WORD_NEG_ONE;
							ld_status = ST_EMPTY;
						end else begin
							mem_re      = 1'b1;
							mem_raddr_a = '0;
							mem_raddr_b = AW'(cnt_dec);
							state_d     = S_POP;
						end
					end
				end
			end
			S_POP: begin
				load     = 1'b1;
				ld_max   = mem_rdata_a;
				ld_count = cnt_dec;
				cnt_d    = cnt_dec;
				v_d      = mem_rdata_b;
				p_d      = CW'(1);
				if (cnt_dec >= CW'(2)) begin
					mem_re      = 1'b1;
					mem_raddr_a = AW'(1);
					mem_raddr_b = AW'(2);
					state_d     = S_DN;
				end else if (cnt_dec == CW'(1)) begin
					state_d = S_FIN;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_UP: begin
				mem_we = 1'b1;
				if (!up_gt) begin
					mem_wdata = v_q;
					state_d   = S_IDLE;
				end else begin
					mem_wdata = mem_rdata_a;
					p_d       = p_half;
					if (p_half > CW'(1)) begin
						mem_re      = 1'b1;
						mem_raddr_a = AW'((p_half >> 1) - 1'b1);
					end else begin
						state_d = S_FIN;
					end
				end
			end
			S_DN: begin
				mem_we = 1'b1;
				if (!take_l && !take_r) begin
					mem_wdata = v_q;
					state_d   = S_IDLE;
				end else begin
					mem_wdata = best_val;
					p_d       = best_pos[CW-1:0];
					if (grand <= PW'(cnt_q)) begin
						mem_re      = 1'b1;
						mem_raddr_a = AW'(grand - 1'b1);
						mem_raddr_b = AW'(grand);
					end else begin
						state_d = S_FIN;
					end
				end
			end
			S_FIN: begin
				mem_we  = 1'b1;
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Working registers and the result word.
	always_ff @(posedge clk) begin
		p_q <= p_d;
		v_q <= v_d;
		if (load) begin
			max_q    <= ld_max;
			status_q <= ld_status;
			count_q  <= count_t'(ld_count);
		end
	end

	assign out_valid = out_valid_q;
	assign max_value = max_q;
	assign status    = status_q;
	assign count     = count_q;

endmodule

>>> sv/max_heap_priority_queue.sv
// ----------------------------------------------------------------------------
// max_heap_priority_queue
// Binary max-heap of signed 32-bit words held 1-based in a two-read memory.
// ----------------------------------------------------------------------------
// Insert: result word registered in the cycle after acceptance; busy while the value climbs.
// Remove: root and last are read on acceptance, the result word is loaded in the pop state, then the hole descends.
// One memory read per heap level; a new word is taken only once the previous one has finished.
// Full inserts and empty removals answer at once; a stalled result word holds off input.
// Reset clears the element count and the sequencer; heap memory is not cleared.
module max_heap_priority_queue #(
	parameter int CAPACITY = 1024
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  hpq_pkg::op_t      op,
	input  hpq_pkg::word_t    value,
	output logic              out_valid,
	input  logic              out_stall,
	output hpq_pkg::word_t    max_value,
	output hpq_pkg::status_t  status,
	output hpq_pkg::count_t   count
);
	import hpq_pkg::*;

	localparam int AW = $clog2(CAPACITY);
	localparam count_t CAP_CNT = count_t'(CAPACITY);

	logic          mem_we, mem_re;
	logic [AW-1:0] mem_waddr, mem_raddr_a, mem_raddr_b;
	word_t         mem_wdata, mem_rdata_a, mem_rdata_b;

	// Heap memory.
	hpq_ram #(
		.DEPTH (CAPACITY),
		.AW    (AW)
	) u_ram (
		.clk     (clk),
		.we      (mem_we),
		.waddr   (mem_waddr),
		.wdata   (mem_wdata),
		.re      (mem_re),
		.raddr_a (mem_raddr_a),
		.raddr_b (mem_raddr_b),
		.rdata_a (mem_rdata_a),
		.rdata_b (mem_rdata_b)
	);

	// Insert and remove sequencer.
	hpq_ctrl #(
		.CAPACITY (CAPACITY)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.op          (op),
		.value       (value),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.max_value   (max_value),
		.status      (status),
		.count       (count),
		.mem_we      (mem_we),
		.mem_waddr   (mem_waddr),
		.mem_wdata   (mem_wdata),
		.mem_re      (mem_re),
		.mem_raddr_a (mem_raddr_a),
		.mem_raddr_b (mem_raddr_b),
		.mem_rdata_a (mem_rdata_a),
		.mem_rdata_b (mem_rdata_b)
	);

	// An empty removal reports an empty heap and the marker value.
	a_empty_word: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == ST_EMPTY) |-> (count == '0 && max_value == WORD_NEG_ONE))
		else $error("empty word carries wrong count or value");

	// A dropped insert is only reported when the heap is full.
	a_full_word: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == ST_FULL) |-> (count == CAP_CNT && max_value == '0))
		else $error("full word carries wrong count or value");

	// An accepted insert always leaves a word valid in the following cycle.
	a_word_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (out_valid || $past(op) == OP_REMOVE))
		else $error("insert accepted without a result word");

	// The memory is never written while an item is being accepted.
	a_idle_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |-> !mem_we)
		else $error("memory written during acceptance");

endmodule

>>> test/tb_max_heap_priority_queue.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_max_heap_priority_queue
// Self-checking bench for the max-heap priority queue. A queue of words is
// built up front and sent with random gaps. Each accepted word is applied to
// a software heap of the same capacity, and every answer from the block is
// compared field by field with the oldest answer due. The run has a directed
// opening, a mixed phase, a fill to capacity with dropped inserts, and a
// drain phase.
// ----------------------------------------------------------------------------
module tb_max_heap_priority_queue;
	import hpq_pkg::*;

	localparam int HEAP_CAP      = 1024;
	localparam int IDLE_PCT      = 27;
	localparam int CYCLE_LIMIT   = 500000;
	localparam int SETTLE_CYCLES = 40;
	localparam int CALM_FROM     = 2000;
	localparam int CALM_TO       = 5000;

	typedef struct {
		op_t   op;
		word_t value;
		bit    hold;
	} heap_word_t;

	typedef struct {
		word_t   max_value;
		status_t status;
		count_t  count;
	} heap_answer_t;

	logic    clk       = 1'b0;
	logic    arst_n    = 1'b0;
	logic    in_valid  = 1'b0;
	logic    in_stall;
	op_t     op        = OP_INSERT;
	word_t   value     = '0;
	logic    out_valid;
	logic    out_stall = 1'b0;
	word_t   max_value;
	status_t status;
	count_t  count;

	heap_word_t   words_to_send[$];
	heap_answer_t answers_due[$];
	heap_word_t   next_word;
	heap_answer_t oldest_answer;

	// Software copy of the heap, 1-based.
	word_t heap_mem [1:HEAP_CAP];
	int    heap_len = 0;

	int cycle_count   = 0;
	int mismatches    = 0;
	int answers_seen  = 0;
	int inserts_kept  = 0;
	int inserts_full  = 0;
	int removes_kept  = 0;
	int removes_empty = 0;
	int peak_len      = 0;
	int plan_len      = 0;
	bit calm;
	bit go;

	max_heap_priority_queue #(
		.CAPACITY (HEAP_CAP)
	) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.op        (op),
		.value     (value),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.max_value (max_value),
		.status    (status),
		.count     (count)
	);

	always #5 clk = ~clk;

	// A stretch of the run in which neither side idles.
	assign calm = (cycle_count >= CALM_FROM) && (cycle_count < CALM_TO);

	// Applies one word to the software heap and gives the answer it should cause.
	function automatic heap_answer_t heap_answer(input op_t w_op, input word_t w_value);
		heap_answer_t ans;
		int           p;
		int           best;
		word_t        tmp;
		ans.max_value = '0;
		ans.status    = ST_OK;
		if (w_op == OP_INSERT) begin
			if (heap_len >= HEAP_CAP) begin
				ans.status = ST_FULL;
				inserts_full++;
			end else begin
				heap_len++;
				heap_mem[heap_len] = w_value;
				p = heap_len;
				// Climb while strictly greater than the parent.
				while (p > 1 && heap_mem[p] > heap_mem[p / 2]) begin
					tmp              = heap_mem[p];
					heap_mem[p]      = heap_mem[p / 2];
					heap_mem[p / 2]  = tmp;
					p                = p / 2;
				end
				inserts_kept++;
				if (heap_len > peak_len)
					peak_len = heap_len;
			end
		end else begin
			if (heap_len == 0) begin
				ans.max_value = WORD_NEG_ONE;
				ans.status    = ST_EMPTY;
				removes_empty++;
			end else begin
				ans.max_value = heap_mem[1];
				heap_mem[1]   = heap_mem[heap_len];
				heap_len--;
				p = 1;
				// Descend towards a strictly larger child; left is tried first.
				forever begin
					best = p;
					if (2 * p <= heap_len && heap_mem[2 * p] > heap_mem[best])
						best = 2 * p;
					if (2 * p + 1 <= heap_len && heap_mem[2 * p + 1] > heap_mem[best])
						best = 2 * p + 1;
					if (best == p)
						break;
					tmp            = heap_mem[p];
					heap_mem[p]    = heap_mem[best];
					heap_mem[best] = tmp;
					p              = best;
				end
				removes_kept++;
			end
		end
		ans.count = count_t'(heap_len);
		return ans;
	endfunction

	task automatic log_mismatch(input string msg);
		mismatches++;
		$display("MISMATCH at cycle %0d: %s", cycle_count, msg);
	endtask

	// Queues one word and keeps a rough track of the occupancy it leads to.
	task automatic add_word(input op_t w_op, input word_t w_value, input bit hold);
		heap_word_t w;
		w.op    = w_op;
		w.value = w_value;
		w.hold  = hold;
		words_to_send.insert(words_to_send.size(), w);
		if (w_op == OP_INSERT && plan_len < HEAP_CAP)
			plan_len++;
		else if (w_op == OP_REMOVE && plan_len > 0)
			plan_len--;
	endtask

	// Random word: extremes, a narrow band that gives many equal keys, or any value.
	task automatic add_random(input int insert_pct, input bit hold);
		word_t v;
		int    pick;
		pick = $urandom_range(0, 99);
		if (pick < 15) begin
			case ($urandom_range(0, 4))
				0:       v = 32'sh7fffffff;
				1:       v = 32'sh80000000;
				2:       v = '0;
				3:       v = -32'sd1;
				default: v = 32'sd1;
			endcase
		end else if (pick < 50) begin
			v = word_t'(int'($urandom_range(0, 16)) - 8);
		end else begin
			v = word_t'($urandom);
		end
		add_word(($urandom_range(0, 99) < insert_pct) ? OP_INSERT : OP_REMOVE, v, hold);
	endtask

	// Driver: applies each accepted word to the software heap and offers the next.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			op       <= OP_INSERT;
			value    <= '0;
		end else begin
			if (in_valid && !in_stall)
				answers_due.insert(answers_due.size(), heap_answer(op, value));
			if (!in_valid || !in_stall) begin
				go = calm || ($urandom_range(0, 99) >= IDLE_PCT);
				if (words_to_send.size() != 0 && words_to_send[0].hold &&
				    answers_due.size() != 0)
					go = 1'b0;
				if (words_to_send.size() != 0 && go) begin
					next_word = words_to_send.pop_front();
					in_valid <= 1'b1;
					op       <= next_word.op;
					value    <= next_word.value;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: checks every accepted answer against the oldest one due.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				answers_seen++;
				if (answers_due.size() == 0) begin
					log_mismatch($sformatf("answer with none due: max %0d status %0d count %0d",
						max_value, status, count));
				end else begin
					oldest_answer = answers_due.pop_front();
					if (max_value !== oldest_answer.max_value)
						log_mismatch($sformatf("max_value %0d, wanted %0d",
							max_value, oldest_answer.max_value));
					if (status !== oldest_answer.status)
						log_mismatch($sformatf("status %0d, wanted %0d",
							status, oldest_answer.status));
					if (count !== oldest_answer.count)
						log_mismatch($sformatf("count %0d, wanted %0d",
							count, oldest_answer.count));
				end
			end
			out_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Cycle limit reached with %0d words unsent and %0d answers due",
				words_to_send.size(), answers_due.size());
			$display("tb_max_heap_priority_queue: done, errors");
			$finish;
		end
	end

	initial begin
		// Directed opening: removal from empty, extreme keys, equal keys, drain past empty.
		add_word(OP_REMOVE, 32'sh12345678, 1'b0);
		add_word(OP_INSERT, 32'sh7fffffff, 1'b0);
		add_word(OP_INSERT, 32'sh80000000, 1'b0);
		add_word(OP_INSERT, 32'sd0, 1'b0);
		add_word(OP_INSERT, -32'sd1, 1'b0);
		add_word(OP_INSERT, 32'sd1, 1'b0);
		add_word(OP_INSERT, 32'sd5, 1'b0);
		add_word(OP_INSERT, 32'sd5, 1'b0);
		add_word(OP_INSERT, 32'sd5, 1'b0);
		add_word(OP_INSERT, 32'sh80000001, 1'b0);
		add_word(OP_INSERT, 32'sh7ffffffe, 1'b0);
		repeat (11)
			add_word(OP_REMOVE, word_t'($urandom), 1'b0);

		// Mixed traffic around a small heap, starting only once the queue has answered all.
		add_random(55, 1'b1);
		repeat (199)
			add_random(55, 1'b0);

		// Fill to capacity, then push on with mostly dropped inserts.
		while (plan_len < HEAP_CAP)
			add_random(95, 1'b0);
		repeat (40)
			add_random(75, 1'b0);

		// Drain, after a pause with the queue full and quiet.
		add_random(10, 1'b1);
		repeat (399)
			add_random(10, 1'b0);

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (words_to_send.size() != 0 || in_valid || answers_due.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);

		$display("Checked %0d answers: %0d inserts kept, %0d dropped at full, %0d removals,",
			answers_seen, inserts_kept, inserts_full, removes_kept);
		$display("%0d removals from an empty heap, peak occupancy %0d of %0d.",
			removes_empty, peak_len, HEAP_CAP);
		if (mismatches == 0)
			$display("tb_max_heap_priority_queue: done, clean");
		else
			$display("tb_max_heap_priority_queue: done, errors");
		$finish;
	end

endmodule
